// ===== src/pbag_pkg.sv =====
package pbag_pkg;

    // Frame and tile limits.
    localparam int MAX_WIDTH       = 4096;
    localparam int MAX_HEIGHT      = 4096;
    localparam int MAX_BLOCK_WIDTH = 16;
    localparam int GLYPH_COUNT     = 10;

    // Field and state widths.
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int DIM_W    = 13;
    localparam int BW_W     = 5;
    localparam int BH_W     = BW_W + 1;
    localparam int OFFX_W   = $clog2(MAX_BLOCK_WIDTH);
    localparam int OFFY_W   = OFFX_W + 1;
    localparam int COLOR_W  = 8;
    localparam int LUMA_W   = 8;
    localparam int LUMA_ACC_W = 24;
    localparam int SUM_W    = 17;
    localparam int LEVEL_W  = 4;
    localparam int GLYPH_W  = 7;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [BW_W-1:0]  BLOCK_WIDTH_RESET  = 5'd4;
    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RESET = 13'd480;

    // Rec.709 luma weights in 16-bit fixed point; they sum to 65536.
    localparam logic [LUMA_ACC_W-1:0] LUMA_WR = 24'd13933;
    localparam logic [LUMA_ACC_W-1:0] LUMA_WG = 24'd46871;
    localparam logic [LUMA_ACC_W-1:0] LUMA_WB = 24'd4732;
    localparam int LUMA_SHIFT = 16;

    // The tile mean is a multiplication by ceil(2^26 / (2*bw*bw)).
    // This is exact for every sum below 2^17 and every divisor up to 512.
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 26;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 7'd32;

    typedef struct packed {
        logic [LUMA_W-1:0] luma;
        logic [COL_W-1:0]  idx;
        logic              first;
        logic              interior;
        logic              last;
        logic              row_end;
    } pixel_ctl_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int hi);
        logic [DIM_W-1:0] r;
        if (v == '0) r = DIM_W'(1);
        else if (int'(v) > hi) r = DIM_W'(hi);
        else r = v;
        return r;
    endfunction

    function automatic logic [BW_W-1:0] clamp_bw(input logic [BW_W-1:0] v);
        logic [BW_W-1:0] r;
        if (v == '0) r = BW_W'(1);
        else if (int'(v) > MAX_BLOCK_WIDTH) r = BW_W'(MAX_BLOCK_WIDTH);
        else r = v;
        return r;
    endfunction

    function automatic logic [RECIP_W-1:0] tile_recip(input logic [BW_W-1:0] bw);
        logic [RECIP_W-1:0] r;
        unique case (bw)
            5'd1:    r = 26'd33554432;
            5'd2:    r = 26'd8388608;
            5'd3:    r = 26'd3728271;
            5'd4:    r = 26'd2097152;
            5'd5:    r = 26'd1342178;
            5'd6:    r = 26'd932068;
            5'd7:    r = 26'd684785;
            5'd8:    r = 26'd524288;
            5'd9:    r = 26'd414253;
            5'd10:   r = 26'd335545;
            5'd11:   r = 26'd277310;
            5'd12:   r = 26'd233017;
            5'd13:   r = 26'd198547;
            5'd14:   r = 26'd171197;
            5'd15:   r = 26'd149131;
            5'd16:   r = 26'd131072;
            default: r = '0;
        endcase
        return r;
    endfunction

    // floor(v*GLYPH_COUNT/255), saturated at GLYPH_COUNT-1, by threshold compares.
    function automatic logic [LEVEL_W-1:0] glyph_level(input logic [LUMA_W-1:0] v);
        logic [11:0]        scaled;
        logic [LEVEL_W-1:0] lvl;
        scaled = 12'(v) * 12'(GLYPH_COUNT);
        lvl = '0;
        for (int k = 1; k < GLYPH_COUNT; k++) begin
            if (scaled >= 12'(255 * k)) lvl = LEVEL_W'(k);
        end
        return lvl;
    endfunction

    function automatic logic [GLYPH_W-1:0] palette(input logic [LEVEL_W-1:0] lvl);
        logic [GLYPH_W-1:0] c;
        unique case (lvl)
            4'd0:    c = 7'd64;  // '@'
            4'd1:    c = 7'd37;  // '%'
            4'd2:    c = 7'd36;  // '$'
            4'd3:    c = 7'd61;  // '='
            4'd4:    c = 7'd43;  // '+'
            4'd5:    c = 7'd45;  // '-'
            4'd6:    c = 7'd124; // '|'
            4'd7:    c = 7'd58;  // ':'
            4'd8:    c = 7'd46;  // '.'
            default: c = GLYPH_SPACE;
        endcase
        return c;
    endfunction

endpackage

// ===== src/pixel_block_to_ascii_glyph.sv =====
// ASCII-art quantizer for a raster pixel stream.
// Input channel: red, green and blue of one pixel per item, in raster order,
// moved when in_valid is high and in_stall is low. Output channel: one item per
// tile (glyph, level and end_of_line), moved when out_valid is high and
// out_stall is low. An item appears when the last pixel of its tile arrives;
// end_of_line marks the last tile of a tile row.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. Index 0 is the
// tile width, 1 the image width, 2 the image height. Any write to one of them
// restarts the frame at pixel (0,0); cfg_ready is always high.
// Throughput: one pixel per clock while in_stall is low. Each pixel does a single
// read-modify-write of the per-column tile sum memory, with the last write forwarded
// to the next read of the same column, so back-to-back pixels of one tile never wait.
// A result is registered in turn after the memory read, the sum update and the
// reciprocal multiply, and all of these stages hold while in_stall is high.
// When the receiver stalls with a result waiting, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset: registers return to tile width 4 and a 640x480 image, the position goes
// to (0,0) and the pipeline empties. The tile sum memory is not cleared, since
// the first pixel of every tile overwrites its entry.
module pixel_block_to_ascii_glyph (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pbag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pbag_pkg::DIM_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [pbag_pkg::COLOR_W-1:0]    red,
    input  logic [pbag_pkg::COLOR_W-1:0]    green,
    input  logic [pbag_pkg::COLOR_W-1:0]    blue,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [pbag_pkg::GLYPH_W-1:0]    glyph,
    output logic [pbag_pkg::LEVEL_W-1:0]    level,
    output logic                            end_of_line
);
    import pbag_pkg::*;

    // Configuration registers and their effective (clamped) values.
    logic [BW_W-1:0]  block_width_reg;
    logic [DIM_W-1:0] image_width_reg;
    logic [DIM_W-1:0] image_height_reg;
    logic [BW_W-1:0]  bw_eff;
    logic [BH_W-1:0]  bh_eff;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic             cfg_write;

    // Frame position.
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [OFFX_W-1:0] offx_reg, offx_next;
    logic [OFFY_W-1:0] offy_reg, offy_next;
    logic [COL_W-1:0]  tcol_reg, tcol_next;

    // Pipeline control. The pipeline advances whenever the output register
    // is free or being emptied.
    logic advance;
    logic accept;

    // Per-pixel decode at the input.
    logic [COL_W-1:0]      tile_x;
    logic [ROW_W-1:0]      tile_y;
    logic [LUMA_ACC_W-1:0] luma_acc;
    pixel_ctl_t            pix_ctl;

    // Tile sum memory and the sum update stage.
    logic [SUM_W-1:0] tile_sums_mem [MAX_WIDTH];
    logic [SUM_W-1:0] rd_data_reg;
    logic             s1_valid_reg;
    pixel_ctl_t       s1_reg;
    logic             lw_valid_reg;
    logic [COL_W-1:0] lw_idx_reg;
    logic [SUM_W-1:0] lw_data_reg;
    logic [SUM_W-1:0] old_sum;
    logic [SUM_W-1:0] new_sum;
    logic [SUM_W-1:0] tile_value;
    logic             sum_update;
    logic             mem_write;

    // Mean and glyph stage.
    logic             s2_valid_reg;
    logic [SUM_W-1:0] s2_sum_reg;
    logic             s2_interior_reg;
    logic             s2_row_end_reg;
    logic [PROD_W-1:0] mean_prod;
    logic [LUMA_W-1:0] tile_mean;
    logic [LUMA_W-1:0] shade;
    logic [LEVEL_W-1:0] level_next;

    // Output register.
    logic               out_valid_reg;
    logic [GLYPH_W-1:0] glyph_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               end_of_line_reg;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && (cfg_index == CFG_BLOCK_WIDTH ||
                                     cfg_index == CFG_IMAGE_WIDTH ||
                                     cfg_index == CFG_IMAGE_HEIGHT);

    assign bw_eff = clamp_bw(block_width_reg);
    assign bh_eff = {bw_eff, 1'b0};
    assign w_eff  = clamp_dim(image_width_reg, MAX_WIDTH);
    assign h_eff  = clamp_dim(image_height_reg, MAX_HEIGHT);

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;
    assign accept   = in_valid && advance;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            block_width_reg  <= BLOCK_WIDTH_RESET;
            image_width_reg  <= IMAGE_WIDTH_RESET;
            image_height_reg <= IMAGE_HEIGHT_RESET;
        end
        else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BLOCK_WIDTH:  block_width_reg  <= cfg_data[BW_W-1:0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Decode of the incoming pixel against the current position.
    always_comb
    begin
        tile_x   = col_reg - COL_W'(offx_reg);
        tile_y   = row_reg - ROW_W'(offy_reg);
        luma_acc = LUMA_ACC_W'(red) * LUMA_WR + LUMA_ACC_W'(green) * LUMA_WG
                 + LUMA_ACC_W'(blue) * LUMA_WB;
        pix_ctl.luma     = luma_acc[LUMA_SHIFT +: LUMA_W];
        pix_ctl.idx      = tcol_reg;
        pix_ctl.first    = (offx_reg == '0) && (offy_reg == '0);
        pix_ctl.interior = (DIM_W'(tile_x) + DIM_W'(bw_eff) < w_eff) &&
                           (DIM_W'(tile_y) + DIM_W'(bh_eff) < h_eff);
        pix_ctl.row_end  = (DIM_W'(col_reg) + DIM_W'(1) >= w_eff);
        pix_ctl.last     = (pix_ctl.row_end ||
                            (BW_W'(offx_reg) + BW_W'(1) >= bw_eff)) &&
                           ((DIM_W'(row_reg) + DIM_W'(1) >= h_eff) ||
                            (BH_W'(offy_reg) + BH_W'(1) >= bh_eff));
    end

    // Position update: raster walk with tile offsets, restarted by a register write.
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        offx_next = offx_reg;
        offy_next = offy_reg;
        tcol_next = tcol_reg;
        if (cfg_write) begin
            col_next  = '0;
            row_next  = '0;
            offx_next = '0;
            offy_next = '0;
            tcol_next = '0;
        end
        else if (accept) begin
            if (pix_ctl.row_end) begin
                col_next  = '0;
                offx_next = '0;
                tcol_next = '0;
                if (DIM_W'(row_reg) + DIM_W'(1) >= h_eff) begin
                    row_next  = '0;
                    offy_next = '0;
                end
                else begin
                    row_next  = row_reg + ROW_W'(1);
                    offy_next = (BH_W'(offy_reg) + BH_W'(1) >= bh_eff) ? '0
                              : offy_reg + OFFY_W'(1);
                end
            end
            else begin
                col_next = col_reg + COL_W'(1);
                if (BW_W'(offx_reg) + BW_W'(1) >= bw_eff) begin
                    offx_next = '0;
                    tcol_next = tcol_reg + COL_W'(1);
                end
                else begin
                    offx_next = offx_reg + OFFX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            col_reg  <= '0;
            row_reg  <= '0;
            offx_reg <= '0;
            offy_reg <= '0;
            tcol_reg <= '0;
        end
        else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            offx_reg <= offx_next;
            offy_reg <= offy_next;
            tcol_reg <= tcol_next;
        end
    end

    // Sum update. The entry read for this pixel may predate the write of the
    // pixel just ahead of it, so the most recent write is forwarded on a match.
    always_comb
    begin
        old_sum    = (lw_valid_reg && lw_idx_reg == s1_reg.idx) ? lw_data_reg : rd_data_reg;
        sum_update = s1_reg.first || s1_reg.interior;
        new_sum    = s1_reg.first ? SUM_W'(s1_reg.luma) : old_sum + SUM_W'(s1_reg.luma);
        tile_value = sum_update ? new_sum : old_sum;
        mem_write  = s1_valid_reg && advance && sum_update;
    end

    always_ff @(posedge clk) begin
        if (mem_write) begin
            tile_sums_mem[s1_reg.idx] <= new_sum;
        end
        if (accept) begin
            rd_data_reg <= tile_sums_mem[pix_ctl.idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else begin
            if (advance) begin
                s1_valid_reg <= in_valid;
            end
            if (mem_write) begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            s1_reg <= pix_ctl;
        end
        if (mem_write) begin
            lw_idx_reg  <= s1_reg.idx;
            lw_data_reg <= new_sum;
        end
    end

    // Mean by reciprocal multiply, then palette lookup.
    always_comb
    begin
        mean_prod  = PROD_W'(s2_sum_reg) * PROD_W'(tile_recip(bw_eff));
        tile_mean  = mean_prod[RECIP_SHIFT +: LUMA_W];
        shade      = s2_interior_reg ? tile_mean : s2_sum_reg[LUMA_W-1:0];
        level_next = glyph_level(shade);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance) begin
            s2_valid_reg  <= s1_valid_reg && s1_reg.last;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            s2_sum_reg      <= tile_value;
            s2_interior_reg <= s1_reg.interior;
            s2_row_end_reg  <= s1_reg.row_end;
            glyph_reg       <= palette(level_next);
            level_reg       <= level_next;
            end_of_line_reg <= s2_row_end_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign glyph       = glyph_reg;
    assign level       = level_reg;
    assign end_of_line = end_of_line_reg;

`ifndef SYNTHESIS
    a_level_in_palette: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (int'(level_reg) <= GLYPH_COUNT - 1))
        else $error("level beyond the palette");

    a_glyph_matches_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (glyph_reg == palette(level_reg)))
        else $error("glyph does not match level");

    a_offx_in_tile: assert property (@(posedge clk) disable iff (!rst_n)
        BW_W'(offx_reg) < bw_eff)
        else $error("column offset outside the tile");

    a_offy_in_tile: assert property (@(posedge clk) disable iff (!rst_n)
        BH_W'(offy_reg) < bh_eff)
        else $error("row offset outside the tile");

    a_mean_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_interior_reg) |-> (mean_prod[PROD_W-1:RECIP_SHIFT+LUMA_W] == '0))
        else $error("tile mean exceeds the luma range");
`endif

endmodule
